@@ rtl/core/ecmp_pkg.sv @@
`timescale 1ns / 1ps
package ecmp_pkg;

   // default table geometry
   localparam int unsigned DefRouteEntries = 64;
   localparam int unsigned DefHopsPerRoute = 8;

   // egress port number width
   localparam int unsigned PortBits = 6;

   // murmur3 constants
   localparam logic [31:0] MixC1    = 32'hcc9e2d51;
   localparam logic [31:0] MixC2    = 32'h1b873593;
   localparam logic [31:0] MixAdd   = 32'he6546b64;
   localparam logic [31:0] FinC1    = 32'h85ebca6b;
   localparam logic [31:0] FinC2    = 32'hc2b2ae35;
   localparam logic [31:0] KeyBytes = 32'd12;

   // protocols whose ports enter the hash
   localparam logic [7:0] ProtTcp  = 8'h06;
   localparam logic [7:0] ProtUdp  = 8'h11;
   localparam logic [7:0] ProtExtA = 8'hFB;
   localparam logic [7:0] ProtExtB = 8'hFC;
   localparam logic [7:0] ProtExtC = 8'hFD;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      STS_FORWARDED = 3'd0,
      STS_NO_ROUTE  = 3'd1,
      STS_ADDED     = 3'd2,
      STS_FULL      = 3'd3,
      STS_CLEARED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SEARCH,
      S_COMMIT,
      S_DIVIDE,
      S_HOP_RD,
      S_CLEAR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       ready;
      logic       take_item;
      logic       sweep_run;
      logic       div_start;
      logic       hop_read;
      logic       add_commit;
      logic       rsp_load;
      status_type rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       scan_done;
      logic       hash_done;
      logic       hit;
      logic       hops_nz;
      logic       room;
      logic       div_done;
      logic       sweep_last;
      logic       out_free;
   } dp_stat_type;

endpackage

@@ rtl/core/ecmp_hash.sv @@
`timescale 1ns / 1ps
module ecmp_hash
   import ecmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] seed,
   input  logic [31:0] word0,
   input  logic [31:0] word1,
   input  logic [31:0] word2,
   output logic        done,
   output logic [31:0] hash
);

   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic [1:0]  word_ff, word_in;
   logic [1:0]  phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [31:0] cur_word;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] prod;
   logic [31:0] k_rot;
   logic [31:0] h_rot;
   logic [31:0] h_mix;
   logic [31:0] fin_t0;

   // word of the key for the current round
   always_comb begin
      case (word_ff)
         2'd0:    cur_word = word0;
         2'd1:    cur_word = word1;
         default: cur_word = word2;
      endcase
   end

   assign k_rot  = {k_ff[16:0], k_ff[31:17]};
   assign h_rot  = {(h_ff[18:0] ^ k_ff[18:0]), (h_ff[31:19] ^ k_ff[31:19])};
   assign h_mix  = {h_rot[29:0], 2'b00} + h_rot + MixAdd;
   assign fin_t0 = h_ff ^ KeyBytes;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (word_ff != 2'd3) begin
         case (phase_ff)
            2'd0: begin
               mul_a = cur_word;
               mul_b = MixC1;
            end
            2'd1: begin
               mul_a = k_rot;
               mul_b = MixC2;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else begin
         case (phase_ff)
            2'd0: begin
               mul_a = fin_t0 ^ {16'd0, fin_t0[31:16]};
               mul_b = FinC1;
            end
            2'd1: begin
               mul_a = h_ff ^ {13'd0, h_ff[31:13]};
               mul_b = FinC2;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign prod = mul_a * mul_b;

   // round sequencer: three steps per key word, three for the finalizer
   always_comb begin
      h_in     = h_ff;
      k_in     = k_ff;
      word_in  = word_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (start) begin
         h_in     = seed;
         word_in  = 2'd0;
         phase_in = 2'd0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         if (word_ff != 2'd3) begin
            case (phase_ff)
               2'd0:    k_in = prod;
               2'd1:    k_in = prod;
               default: h_in = h_mix;
            endcase
         end else begin
            case (phase_ff)
               2'd0:    h_in = prod;
               2'd1:    h_in = prod;
               default: h_in = h_ff ^ {16'd0, h_ff[31:16]};
            endcase
         end
         if (phase_ff == 2'd2) begin
            phase_in = 2'd0;
            word_in  = word_ff + 2'd1;
            if (word_ff == 2'd3) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      k_ff     <= k_in;
      word_ff  <= word_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign hash = h_ff;

endmodule

@@ rtl/core/ecmp_dp.sv @@
`timescale 1ns / 1ps
module ecmp_dp
   import ecmp_pkg::*;
#(
   parameter int unsigned RouteEntries = DefRouteEntries,
   parameter int unsigned HopsPerRoute = DefHopsPerRoute
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   input  logic [1:0]          req_action,
   input  logic [31:0]         req_src_addr,
   input  logic [31:0]         req_dst_addr,
   input  logic [7:0]          req_protocol,
   input  logic [15:0]         req_src_port,
   input  logic [15:0]         req_dst_port,
   input  logic [5:0]          req_port_index,
   input  logic [31:0]         hash_seed,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [5:0]          rsp_out_port,
   output logic [31:0]         rsp_hash_value
);

   localparam int unsigned IdxW     = (RouteEntries > 1) ? $clog2(RouteEntries) : 1;
   localparam int unsigned CntW     = $clog2(HopsPerRoute + 1);
   localparam int unsigned HopDepth = RouteEntries * HopsPerRoute;
   localparam int unsigned HopW     = (HopDepth > 1) ? $clog2(HopDepth) : 1;

   typedef struct packed {
      logic            valid;
      logic [31:0]     dest;
      logic [CntW-1:0] count;
   } entry_type;

   // route entry and hop memories
   entry_type           ent_mem [RouteEntries];
   logic [PortBits-1:0] hop_mem [HopDepth];

   // captured item
   logic [1:0]          act_ff, act_in;
   logic [31:0]         src_ff, src_in;
   logic [31:0]         dst_ff, dst_in;
   logic [31:0]         pw_ff, pw_in;
   logic [PortBits-1:0] pidx_ff, pidx_in;
   logic                prot_hit;

   // table search
   logic [IdxW:0]       rd_addr_ff, rd_addr_in;
   logic                scan_busy_ff, scan_busy_in;
   logic                scan_done_ff, scan_done_in;
   logic                q_vld_ff;
   logic [IdxW-1:0]     q_idx_ff;
   entry_type           ent_q_ff;
   logic                hit_ff, hit_in;
   logic [IdxW-1:0]     hit_idx_ff, hit_idx_in;
   logic [CntW-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [HopW-1:0]     hit_base_ff, hit_base_in;
   logic                free_ff, free_in;
   logic [IdxW-1:0]     free_idx_ff, free_idx_in;
   logic [HopW-1:0]     free_base_ff, free_base_in;
   logic                issue;
   logic                q_match;
   logic                q_last;

   // clearing sweep
   logic [IdxW-1:0]     sweep_ff, sweep_in;

   // memory write port and hop read port
   logic                ent_we;
   logic [IdxW-1:0]     ent_waddr;
   entry_type           ent_wdata;
   logic                hop_we;
   logic [HopW-1:0]     hop_waddr;
   logic [HopW-1:0]     hop_raddr;
   logic [PortBits-1:0] hop_q_ff;

   // bit-serial modulo
   logic [31:0]         dq_ff, dq_in;
   logic [CntW:0]       rem_ff, rem_in;
   logic [4:0]          div_cnt_ff, div_cnt_in;
   logic                div_busy_ff, div_busy_in;
   logic                div_done_ff, div_done_in;
   logic [CntW:0]       rem_trial;

   // hash unit
   logic                hash_done;
   logic [31:0]         hash_val;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [5:0]          rsp_port_ff, rsp_port_in;
   logic [31:0]         rsp_hash_ff, rsp_hash_in;
   logic                room;

   // item capture
   assign prot_hit = (req_protocol == ProtTcp) || (req_protocol == ProtUdp) ||
                     (req_protocol == ProtExtA) || (req_protocol == ProtExtB) ||
                     (req_protocol == ProtExtC);

   always_comb begin
      act_in  = act_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      pw_in   = pw_ff;
      pidx_in = pidx_ff;
      if (cmd.take_item) begin
         act_in  = req_action;
         src_in  = req_src_addr;
         dst_in  = req_dst_addr;
         pw_in   = prot_hit ? {req_dst_port, req_src_port} : 32'd0;
         pidx_in = req_port_index[PortBits-1:0];
      end
   end

   ecmp_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.take_item),
      .seed  (hash_seed),
      .word0 (src_ff),
      .word1 (dst_ff),
      .word2 (pw_ff),
      .done  (hash_done),
      .hash  (hash_val)
   );

   // search: one entry read per cycle, compare on the registered data
   assign issue   = scan_busy_ff && (rd_addr_ff < (IdxW + 1)'(RouteEntries));
   assign q_match = ent_q_ff.valid && (ent_q_ff.dest == dst_ff);
   assign q_last  = (q_idx_ff == IdxW'(RouteEntries - 1));

   always_comb begin
      rd_addr_in   = rd_addr_ff;
      scan_busy_in = scan_busy_ff;
      scan_done_in = scan_done_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      hit_base_in  = hit_base_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      free_base_in = free_base_ff;
      if (cmd.take_item) begin
         rd_addr_in   = '0;
         scan_busy_in = (req_action == ACT_LOOKUP) || (req_action == ACT_ADD);
         scan_done_in = 1'b0;
         hit_in       = 1'b0;
         free_in      = 1'b0;
      end else if (scan_busy_ff) begin
         if (issue) begin
            rd_addr_in = rd_addr_ff + 1'b1;
         end
         if (q_vld_ff) begin
            if (q_match) begin
               hit_in      = 1'b1;
               hit_idx_in  = q_idx_ff;
               hit_cnt_in  = ent_q_ff.count;
               hit_base_in = HopW'(HopW'(q_idx_ff) * HopW'(HopsPerRoute));
            end
            if (!ent_q_ff.valid && !free_ff) begin
               free_in      = 1'b1;
               free_idx_in  = q_idx_ff;
               free_base_in = HopW'(HopW'(q_idx_ff) * HopW'(HopsPerRoute));
            end
            if (q_match || q_last) begin
               scan_busy_in = 1'b0;
               scan_done_in = 1'b1;
            end
         end
      end
   end

   assign room = hit_ff ? (hit_cnt_ff < CntW'(HopsPerRoute)) : free_ff;

   // clearing sweep counter wraps after the last entry
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_run) begin
         sweep_in = (sweep_ff == IdxW'(RouteEntries - 1)) ? '0 : sweep_ff + 1'b1;
      end
   end

   // entry and hop write port
   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = sweep_ff;
      ent_wdata = '0;
      hop_we    = 1'b0;
      hop_waddr = free_base_ff;
      if (cmd.sweep_run) begin
         ent_we = 1'b1;
      end else if (cmd.add_commit) begin
         ent_we       = 1'b1;
         hop_we       = 1'b1;
         ent_wdata.valid = 1'b1;
         ent_wdata.dest  = dst_ff;
         if (hit_ff) begin
            ent_waddr       = hit_idx_ff;
            ent_wdata.count = hit_cnt_ff + 1'b1;
            hop_waddr       = hit_base_ff + HopW'(hit_cnt_ff);
         end else begin
            ent_waddr       = free_idx_ff;
            ent_wdata.count = CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (issue) begin
         ent_q_ff <= ent_mem[rd_addr_ff[IdxW-1:0]];
      end
      if (hop_we) begin
         hop_mem[hop_waddr] <= pidx_ff;
      end
      if (cmd.hop_read) begin
         hop_q_ff <= hop_mem[hop_raddr];
      end
   end

   assign hop_raddr = hit_base_ff + HopW'(rem_ff[CntW-1:0]);

   // hash modulo hop count, one quotient bit per cycle
   assign rem_trial = {rem_ff[CntW-1:0], dq_ff[31]};

   always_comb begin
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      div_busy_in = div_busy_ff;
      div_done_in = div_done_ff;
      if (cmd.div_start) begin
         dq_in       = hash_val;
         rem_in      = '0;
         div_cnt_in  = '0;
         div_busy_in = 1'b1;
         div_done_in = 1'b0;
      end else if (div_busy_ff) begin
         dq_in      = {dq_ff[30:0], 1'b0};
         rem_in     = (rem_trial >= {1'b0, hit_cnt_ff}) ?
                      rem_trial - {1'b0, hit_cnt_ff} : rem_trial;
         div_cnt_in = div_cnt_ff + 5'd1;
         if (div_cnt_ff == 5'd31) begin
            div_busy_in = 1'b0;
            div_done_in = 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_hash_in   = rsp_hash_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_port_in   = (cmd.rsp_status == STS_FORWARDED) ? 6'(hop_q_ff) : 6'd0;
         rsp_hash_in   = (act_ff == ACT_LOOKUP) ? hash_val : 32'd0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      pw_ff         <= pw_in;
      pidx_ff       <= pidx_in;
      rd_addr_ff    <= rd_addr_in;
      q_idx_ff      <= rd_addr_ff[IdxW-1:0];
      hit_idx_ff    <= hit_idx_in;
      hit_cnt_ff    <= hit_cnt_in;
      hit_base_ff   <= hit_base_in;
      free_idx_ff   <= free_idx_in;
      free_base_ff  <= free_base_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_hash_ff   <= rsp_hash_in;
      if (reset) begin
         scan_busy_ff <= 1'b0;
         scan_done_ff <= 1'b0;
         q_vld_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         sweep_ff     <= '0;
         div_busy_ff  <= 1'b0;
         div_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_busy_ff <= scan_busy_in;
         scan_done_ff <= scan_done_in;
         q_vld_ff     <= issue && !cmd.take_item;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         sweep_ff     <= sweep_in;
         div_busy_ff  <= div_busy_in;
         div_done_ff  <= div_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status to the controller
   always_comb begin
      stat.action     = act_ff;
      stat.scan_done  = scan_done_ff;
      stat.hash_done  = hash_done;
      stat.hit        = hit_ff;
      stat.hops_nz    = (hit_cnt_ff != '0);
      stat.room       = room;
      stat.div_done   = div_done_ff;
      stat.sweep_last = (sweep_ff == IdxW'(RouteEntries - 1));
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_port   = rsp_port_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

@@ rtl/core/ecmp_ctrl.sv @@
`timescale 1ns / 1ps
module ecmp_ctrl
   import ecmp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_action,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      search_end;
   logic      fwd;

   assign search_end = stat.scan_done && stat.hash_done;
   assign fwd        = stat.hit && stat.hops_nz;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  ACT_LOOKUP, ACT_ADD: state_in = S_SEARCH;
                  ACT_CLEAR:           state_in = S_CLEAR;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_SEARCH: begin
            if (search_end) begin
               if (stat.action == ACT_ADD) state_in = S_COMMIT;
               else if (fwd)               state_in = S_DIVIDE;
               else                        state_in = S_DONE;
            end
         end
         S_COMMIT: state_in = S_DONE;
         S_DIVIDE: begin
            if (stat.div_done) state_in = S_HOP_RD;
         end
         S_HOP_RD: state_in = S_DONE;
         S_CLEAR: begin
            if (stat.sweep_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = STS_NO_ROUTE;
      cmd.ready      = (state_ff == S_IDLE);
      cmd.take_item  = (state_ff == S_IDLE) && req_valid;
      cmd.sweep_run  = (state_ff == S_INIT) || (state_ff == S_CLEAR);
      cmd.div_start  = (state_ff == S_SEARCH) && search_end &&
                       (stat.action == ACT_LOOKUP) && fwd;
      cmd.hop_read   = (state_ff == S_HOP_RD);
      cmd.add_commit = (state_ff == S_COMMIT) && stat.room;
      cmd.rsp_load   = (state_ff == S_DONE) && stat.out_free;
      unique case (stat.action)
         ACT_LOOKUP: cmd.rsp_status = fwd ? STS_FORWARDED : STS_NO_ROUTE;
         ACT_ADD:    cmd.rsp_status = stat.room ? STS_ADDED : STS_FULL;
         ACT_CLEAR:  cmd.rsp_status = STS_CLEARED;
         default:    cmd.rsp_status = STS_NO_ROUTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/ecmp_next_hop_select.sv @@
`timescale 1ns / 1ps
// ECMP next-hop selector. Route entries map a destination address to up to
// HOPS_PER_ROUTE egress ports; a lookup hashes source address, destination
// address and port word with 32-bit MurmurHash3 (seed from csr_hash_seed) and
// picks hop (hash mod hop count). One item is worked at a time. The entry
// table is searched one entry per cycle through a single read port. A lookup
// runs the search, then on a hit with hops a bit-serial modulo and a hop
// read, then the result; an add runs the search, a commit and the result; a
// clear sweeps all entries; a search stops early on a match. After reset a
// clearing pass over all entries runs before the first item is taken. A
// finished result waits in an output register while the next item is
// accepted.
module ecmp_next_hop_select
   import ecmp_pkg::*;
#(
   parameter int unsigned ROUTE_ENTRIES  = DefRouteEntries,
   parameter int unsigned HOPS_PER_ROUTE = DefHopsPerRoute
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [5:0]  req_port_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_out_port,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_hash_seed
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic [31:0]  seed_ff, seed_in;

   // seed register
   assign csr_ready = 1'b1;
   assign seed_in   = (csr_valid && csr_ready) ? csr_hash_seed : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   ecmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   ecmp_dp #(
      .RouteEntries (ROUTE_ENTRIES),
      .HopsPerRoute (HOPS_PER_ROUTE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_src_addr   (req_src_addr),
      .req_dst_addr   (req_dst_addr),
      .req_protocol   (req_protocol),
      .req_src_port   (req_src_port),
      .req_dst_port   (req_dst_port),
      .req_port_index (req_port_index),
      .hash_seed      (seed_ff),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_port   (rsp_out_port),
      .rsp_hash_value (rsp_hash_value)
   );

   assign req_stall = !cmd.ready;

`ifndef ASSERT_OFF
   // one item at a time: an accepted beat closes the input side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat accepted while an item is in progress");

   // a new result comes only from a controller load
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("result appeared without a load");

   // only forwarded results carry a port
   a_port_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STS_FORWARDED)) |-> (rsp_out_port == 6'd0))
      else $error("port set on a non-forwarded result");

   // table sweep and add never share the write port
   a_write_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sweep_run && cmd.add_commit))
      else $error("sweep and add write in the same cycle");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top
   import ecmp_pkg::*;
;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [31:0] req_src_addr;
   logic [31:0] req_dst_addr;
   logic [7:0]  req_protocol;
   logic [15:0] req_src_port;
   logic [15:0] req_dst_port;
   logic [5:0]  req_port_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_out_port;
   logic [31:0] rsp_hash_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_hash_seed;

   localparam int Entries   = 64;
   localparam int HopsMax   = 8;
   localparam int CycleCap  = 3000000;
   localparam int DrainWait = 200;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [5:0]  port_index;
   } packet_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  out_port;
      logic [31:0] hash_value;
   } verdict_type;

   ecmp_next_hop_select dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_src_addr(req_src_addr), .req_dst_addr(req_dst_addr),
      .req_protocol(req_protocol), .req_src_port(req_src_port),
      .req_dst_port(req_dst_port), .req_port_index(req_port_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_port(rsp_out_port), .rsp_hash_value(rsp_hash_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_hash_seed(csr_hash_seed)
   );

   // shadow route table and seed
   logic [31:0] seed_q;
   logic        tbl_valid[Entries];
   logic [31:0] tbl_dest[Entries];
   int          tbl_count[Entries];
   logic [5:0]  tbl_hops[Entries][HopsMax];

   packet_type  pending_pkts[$];
   verdict_type expected_verdicts[$];
   int       errors;
   int       cycles;
   bit       stim_done;
   int       gap_left;
   int       stall_left;
   logic [31:0] dest_pool[16];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] rotl(logic [31:0] v, int r);
      return (v << r) | (v >> (32 - r));
   endfunction

   function automatic logic [31:0] mix_round(logic [31:0] h, logic [31:0] k);
      k = k * MixC1;
      k = rotl(k, 15);
      k = k * MixC2;
      h = h ^ k;
      h = rotl(h, 13);
      return h * 32'd5 + MixAdd;
   endfunction

   function automatic logic [31:0] flow_hash(packet_type p);
      logic [31:0] h;
      logic [31:0] pw;
      pw = 0;
      if (p.protocol inside {ProtTcp, ProtUdp, ProtExtA, ProtExtB, ProtExtC})
         pw = {p.dst_port, p.src_port};
      h = seed_q;
      h = mix_round(h, p.src_addr);
      h = mix_round(h, p.dst_addr);
      h = mix_round(h, pw);
      h = h ^ KeyBytes;
      h = h ^ (h >> 16);
      h = h * FinC1;
      h = h ^ (h >> 13);
      h = h * FinC2;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // route table behavior for one packet
   function automatic verdict_type route_packet(packet_type p);
      verdict_type v;
      int hit;
      int slot;
      hit = -1;
      slot = -1;
      v = '0;
      v.status = STS_NO_ROUTE;
      for (int i = 0; i < Entries; i++)
         if (hit < 0 && tbl_valid[i] && tbl_dest[i] == p.dst_addr) hit = i;
      case (p.action)
         ACT_LOOKUP: begin
            v.hash_value = flow_hash(p);
            if (hit >= 0 && tbl_count[hit] != 0) begin
               v.out_port = tbl_hops[hit][v.hash_value % tbl_count[hit]];
               v.status = STS_FORWARDED;
            end
         end
         ACT_ADD: begin
            if (hit < 0) begin
               for (int i = Entries - 1; i >= 0; i--)
                  if (!tbl_valid[i]) slot = i;
               if (slot >= 0) begin
                  tbl_valid[slot] = 1;
                  tbl_dest[slot] = p.dst_addr;
                  tbl_count[slot] = 1;
                  tbl_hops[slot][0] = p.port_index;
                  v.status = STS_ADDED;
               end else v.status = STS_FULL;
            end else if (tbl_count[hit] < HopsMax) begin
               tbl_hops[hit][tbl_count[hit]] = p.port_index;
               tbl_count[hit]++;
               v.status = STS_ADDED;
            end else v.status = STS_FULL;
         end
         ACT_CLEAR: begin
            for (int i = 0; i < Entries; i++) tbl_valid[i] = 0;
            v.status = STS_CLEARED;
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   function automatic packet_type rand_packet(int kind);
      packet_type p;
      p.action = ACT_LOOKUP;
      p.src_addr = $urandom();
      p.dst_addr = ($urandom_range(0, 9) < 8) ? dest_pool[$urandom_range(0, 15)]
                                                : $urandom();
      case ($urandom_range(0, 7))
         0: p.protocol = ProtTcp;
         1: p.protocol = ProtUdp;
         2: p.protocol = ProtExtA;
         3: p.protocol = ProtExtB;
         4: p.protocol = ProtExtC;
         default: p.protocol = 8'($urandom_range(0, 255));
      endcase
      p.src_port = 16'($urandom());
      p.dst_port = 16'($urandom());
      p.port_index = 6'($urandom_range(0, 63));
      if (kind < 40) p.action = ACT_ADD;
      else if (kind == 99) p.action = ACT_CLEAR;
      else if (kind == 98) p.action = 2'd3;
      return p;
   endfunction

   // append one packet to the pending queue
   function automatic void queue_pkt(packet_type p);
      pending_pkts.insert(pending_pkts.size(), p);
   endfunction

   // wait until every queued packet got its verdict, then allow settle time
   task automatic drain();
      while (pending_pkts.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_hash_seed <= val;
      do @(posedge clock); while (!csr_ready);
      seed_q = val;
      csr_valid <= 0;
   endtask

   // stimulus
   initial begin
      packet_type p;
      logic [31:0] seeds[5];
      errors = 0;
      stim_done = 0;
      seed_q = 0;
      for (int i = 0; i < Entries; i++) begin
         tbl_valid[i] = 0;
         tbl_count[i] = 0;
      end
      for (int i = 0; i < 16; i++) dest_pool[i] = $urandom();
      dest_pool[0] = 32'h0;
      dest_pool[1] = 32'hFFFF_FFFF;
      reset = 1;
      csr_valid = 0;
      csr_hash_seed = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: miss, adds, extremes, overflow of hop list, odd action, clear
      p = '0;
      queue_pkt(p);
      p = '1;
      p.action = ACT_LOOKUP;
      queue_pkt(p);
      for (int i = 0; i < 9; i++) begin
         p = '0;
         p.action = ACT_ADD;
         p.dst_addr = 32'hFFFF_FFFF;
         p.port_index = (i == 3) ? 6'd63 : 6'(i % 3);
         queue_pkt(p);
      end
      p = '1;
      p.action = ACT_LOOKUP;
      queue_pkt(p);
      p.protocol = 8'd7;
      queue_pkt(p);
      p.protocol = ProtTcp;
      p.src_port = 16'h0;
      queue_pkt(p);
      p = '1;
      queue_pkt(p);
      p.action = ACT_CLEAR;
      queue_pkt(p);
      p.action = ACT_LOOKUP;
      queue_pkt(p);
      drain();

      // fill the whole table then overflow it
      write_seed(32'hFFFF_FFFF);
      for (int i = 0; i < Entries + 2; i++) begin
         p = rand_packet(0);
         p.dst_addr = 32'h1000_0000 + i;
         queue_pkt(p);
         if (i % 8 == 0) begin
            p.action = ACT_LOOKUP;
            queue_pkt(p);
         end
      end
      drain();

      seeds[0] = 32'h0;
      seeds[1] = 32'h8000_0000;
      seeds[2] = $urandom();
      seeds[3] = 32'h0000_0001;
      seeds[4] = $urandom();
      for (int ph = 0; ph < 5; ph++) begin
         write_seed(seeds[ph]);
         for (int i = 0; i < 240; i++) begin
            p = rand_packet((i == 0) ? 99 : $urandom_range(0, 100));
            queue_pkt(p);
         end
         drain();
      end
      stim_done = 1;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_action <= 0;
         req_src_addr <= 0;
         req_dst_addr <= 0;
         req_protocol <= 0;
         req_src_port <= 0;
         req_dst_port <= 0;
         req_port_index <= 0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         // current beat taken or none pending: predict then load the next
         if (req_valid) expected_verdicts.insert(expected_verdicts.size(),
            route_packet({req_action, req_src_addr, req_dst_addr, req_protocol,
                          req_src_port, req_dst_port, req_port_index}));
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else if (pending_pkts.size() != 0) begin
            packet_type n;
            n = pending_pkts.pop_front();
            req_valid <= 1;
            {req_action, req_src_addr, req_dst_addr, req_protocol, req_src_port,
             req_dst_port, req_port_index} <= n;
            gap_left <= pick_gap();
         end else req_valid <= 0;
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected response beat status=%0d", rsp_status);
               errors++;
            end else begin
               verdict_type e;
               e = expected_verdicts.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_out_port !== e.out_port) begin
                  $error("out_port expected %0d actual %0d", e.out_port, rsp_out_port);
                  errors++;
               end
               if (rsp_hash_value !== e.hash_value) begin
                  $error("hash_value expected %h actual %h", e.hash_value,
                         rsp_hash_value);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall <= 0;
         end
      end
   end

   // end of run and watchdog
   always @(posedge clock) begin
      cycles <= (reset) ? 0 : cycles + 1;
      if (stim_done) begin
         if (errors == 0 && expected_verdicts.size() == 0) $display("simulation ok");
         else $display("simulation failed");
         $finish;
      end else if (cycles > CycleCap) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
